/* rtl/mkpc_pkg.sv */
// ----------------------------------------------------------------------------
// mkpc_pkg
// Shared types and constants for the multi-key press classifier.
// ----------------------------------------------------------------------------
package mkpc_pkg;

	localparam int TICK_W      = 16;
	localparam int FLAG_W      = 6;
	localparam int PHASE_W     = 3;
	localparam int LEVELS_W    = 4;
	localparam int KEY_IDX_W   = 2;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;

	typedef logic [TICK_W-1:0]  tick_cnt_t;
	typedef logic [FLAG_W-1:0]  flags_t;
	typedef logic [PHASE_W-1:0] phase_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS  = 1'd1;

	localparam tick_cnt_t LONG_TICKS_RST = TICK_W'(1000 / 10);
	localparam tick_cnt_t GAP_TICKS_RST  = TICK_W'(150 / 10);

	// request opcodes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_CHECK = 1'b1;

	// flag bits
	localparam int FB_HELD   = 0;
	localparam int FB_DOWN   = 1;
	localparam int FB_UP     = 2;
	localparam int FB_SINGLE = 3;
	localparam int FB_DOUBLE = 4;
	localparam int FB_LONG   = 5;

	localparam flags_t F_HELD = 6'h01;

	// press phases
	localparam phase_t PH_IDLE   = 3'd0;
	localparam phase_t PH_TIMING = 3'd1;
	localparam phase_t PH_GAP    = 3'd2;
	localparam phase_t PH_SECOND = 3'd3;
	localparam phase_t PH_LONG   = 3'd4;

	typedef struct packed {
		logic   tick;
		logic   level;
		logic   clear;
		flags_t clear_mask;
	} key_ctl_t;

endpackage

/* rtl/multi_key_press_classifier.sv */
// ----------------------------------------------------------------------------
// multi_key_press_classifier
// Tick-driven press classifier with sticky per-key event flags.
// ----------------------------------------------------------------------------
// Takes one request per cycle while req_stall is low and returns one response
// per request through the input register and the response register. When a
// captured request advances, it updates every key's state in parallel (tick)
// or reads one key's flags and clears the masked bits unless the mask is
// held-only (check), and loads the response register. Stall on the request side
// rises only when both registers are full and the response is stalled.
// Configuration writes are always ready and take effect at once.
module multi_key_press_classifier
	import mkpc_pkg::*;
#(
	parameter int NUM_KEYS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic                  op,
	input  logic [LEVELS_W-1:0]   key_levels,
	input  logic [KEY_IDX_W-1:0]  key_index,
	input  flags_t                flag_mask,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output logic                  hit,
	output flags_t                flags_seen
);

	tick_cnt_t long_ticks_q;
	tick_cnt_t gap_ticks_q;

	logic                 valid_s1;
	logic                 op_s1;
	logic [LEVELS_W-1:0]  levels_s1;
	logic [KEY_IDX_W-1:0] idx_s1;
	flags_t               mask_s1;

	logic   rsp_valid_q;
	logic   hit_q;
	flags_t seen_q;

	logic   adv;
	logic   accept;
	logic   clr_ok;
	flags_t sel_flags;
	logic   hit_d;

	flags_t   key_flags [NUM_KEYS];
	flags_t   key_sel   [NUM_KEYS];
	logic     key_match [NUM_KEYS];
	key_ctl_t key_ctl   [NUM_KEYS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_ticks_q <= LONG_TICKS_RST;
			gap_ticks_q  <= GAP_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LONG_TICKS: long_ticks_q <= cfg_data;
				REG_GAP_TICKS:  gap_ticks_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv       = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !adv;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= op;
			levels_s1 <= key_levels;
			idx_s1    <= key_index;
			mask_s1   <= flag_mask;
		end
	end

	assign clr_ok = (mask_s1 != F_HELD);

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
		logic lvl;
		if (k < LEVELS_W) begin : g_lvl
			assign lvl = levels_s1[k];
		end else begin : g_nolvl
			assign lvl = 1'b0;
		end

		assign key_match[k] = (32'(idx_s1) == k);
		assign key_sel[k]   = key_match[k] ? key_flags[k] : '0;

		assign key_ctl[k].tick       = adv && (op_s1 == OP_TICK);
		assign key_ctl[k].level      = lvl;
		assign key_ctl[k].clear      = adv && (op_s1 == OP_CHECK) && key_match[k]
			&& ((key_flags[k] & mask_s1) != '0) && clr_ok;
		assign key_ctl[k].clear_mask = mask_s1;

		mkpc_key u_key (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (key_ctl[k]),
			.long_ticks (long_ticks_q),
			.gap_ticks  (gap_ticks_q),
			.flags      (key_flags[k])
		);
	end

	always_comb begin
		sel_flags = '0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			sel_flags = sel_flags | key_sel[k];
		end
		if (op_s1 == OP_TICK) sel_flags = '0;
		hit_d = ((sel_flags & mask_s1) != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q  <= hit_d;
			seen_q <= sel_flags;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign hit        = hit_q;
	assign flags_seen = seen_q;

	a_hit_has_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!hit || (flags_seen != '0)))
		else $error("hit reported with no flags seen");

	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !req_stall)
		else $error("request stalled with empty input stage");

	a_adv_loads_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> rsp_valid)
		else $error("advanced request produced no response");

	a_held_request: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("blocked request lost from input stage");

endmodule

/* rtl/mkpc_key.sv */
// ----------------------------------------------------------------------------
// mkpc_key
// Per-key state: level history, phase machine, countdown and sticky flags.
// ----------------------------------------------------------------------------
module mkpc_key
	import mkpc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  key_ctl_t  ctl,
	input  tick_cnt_t long_ticks,
	input  tick_cnt_t gap_ticks,
	output flags_t    flags
);

	logic      last_q, last_d;
	flags_t    flags_q, flags_d;
	phase_t    phase_q, phase_d;
	tick_cnt_t cd_q, cd_d;
	tick_cnt_t cd_dec;

	always_comb begin
		cd_dec  = (cd_q != '0) ? cd_q - TICK_W'(1) : cd_q;
		cd_d    = cd_q;
		last_d  = last_q;
		flags_d = flags_q;
		phase_d = phase_q;
		if (ctl.tick) begin
			cd_d   = cd_dec;
			last_d = ctl.level;
			flags_d[FB_HELD] = ctl.level;
			if (ctl.level && !last_q) flags_d[FB_DOWN] = 1'b1;
			if (!ctl.level && last_q) flags_d[FB_UP] = 1'b1;
			case (phase_q)
				PH_IDLE: begin
					if (ctl.level) begin
						cd_d    = long_ticks;
						phase_d = PH_TIMING;
					end
				end
				PH_TIMING: begin
					if (!ctl.level) begin
						cd_d    = gap_ticks;
						phase_d = PH_GAP;
					end else if (cd_dec == '0) begin
						flags_d[FB_LONG] = 1'b1;
						phase_d = PH_LONG;
					end
				end
				PH_GAP: begin
					if (ctl.level) begin
						flags_d[FB_DOUBLE] = 1'b1;
						phase_d = PH_SECOND;
					end else if (cd_dec == '0) begin
						flags_d[FB_SINGLE] = 1'b1;
						phase_d = PH_IDLE;
					end
				end
				PH_SECOND, PH_LONG: begin
					if (!ctl.level) phase_d = PH_IDLE;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end else if (ctl.clear) begin
			flags_d = flags_q & ~ctl.clear_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= 1'b0;
			flags_q <= '0;
			phase_q <= PH_IDLE;
			cd_q    <= '0;
		end else begin
			last_q  <= last_d;
			flags_q <= flags_d;
			phase_q <= phase_d;
			cd_q    <= cd_d;
		end
	end

	assign flags = flags_q;

endmodule

/* verif/tb_multi_key_press_classifier.sv */
// ----------------------------------------------------------------------------
// tb_multi_key_press_classifier
// Self-checking bench for the four-key press classifier.
// ----------------------------------------------------------------------------
// A behavioral copy of the per-key phase machines predicts every response.
// Each response is compared in order as it is accepted. Stimulus starts with
// a short directed run of press, double, long and single events and checks
// with held-only and zero masks. Random press sequences follow under several
// tick settings, including zero and full-scale. Both sides idle and stall at
// random, and one stretch of output stall backs up the request side.
// ----------------------------------------------------------------------------
module tb_multi_key_press_classifier;
	import mkpc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEYS = 4;

	typedef struct packed {
		logic   hit;
		flags_t flags;
	} press_rsp_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;
	logic                  req_valid  = 1'b0;
	logic                  req_stall;
	logic                  op         = OP_TICK;
	logic [LEVELS_W-1:0]   key_levels = '0;
	logic [KEY_IDX_W-1:0]  key_index  = '0;
	flags_t                flag_mask  = '0;
	logic                  rsp_valid;
	logic                  rsp_stall  = 1'b0;
	logic                  hit;
	flags_t                flags_seen;

	multi_key_press_classifier #(.NUM_KEYS(KEYS)) dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predicted key state
	tick_cnt_t long_ticks;
	tick_cnt_t gap_ticks;
	logic      key_lvl [KEYS];
	flags_t    key_flags [KEYS];
	phase_t    key_phase [KEYS];
	tick_cnt_t key_cnt [KEYS];

	press_rsp_t pending_rsp [$];

	// press pattern generator
	logic gen_lvl [KEYS];
	int   gen_run [KEYS];

	bit sender_idles = 1'b1;
	bit receiver_idles = 1'b1;
	int hold_cycles = 0;
	int errors = 0;
	int n_ticks = 0;
	int n_checks = 0;
	int n_hits = 0;
	int n_settings = 0;

	function automatic void advance_keys(logic [LEVELS_W-1:0] lv);
		for (int k = 0; k < KEYS; k++) begin
			logic   lvl;
			logic   prev;
			flags_t f;
			lvl = lv[k];
			prev = key_lvl[k];
			f = key_flags[k];
			if (key_cnt[k] != 0)
				key_cnt[k] = key_cnt[k] - 1'b1;
			key_lvl[k] = lvl;
			f[FB_HELD] = lvl;
			if (lvl && !prev)
				f[FB_DOWN] = 1'b1;
			if (!lvl && prev)
				f[FB_UP] = 1'b1;
			case (key_phase[k])
				PH_IDLE: begin
					if (lvl) begin
						key_cnt[k] = long_ticks;
						key_phase[k] = PH_TIMING;
					end
				end
				PH_TIMING: begin
					if (!lvl) begin
						key_cnt[k] = gap_ticks;
						key_phase[k] = PH_GAP;
					end else if (key_cnt[k] == 0) begin
						f[FB_LONG] = 1'b1;
						key_phase[k] = PH_LONG;
					end
				end
				PH_GAP: begin
					if (lvl) begin
						f[FB_DOUBLE] = 1'b1;
						key_phase[k] = PH_SECOND;
					end else if (key_cnt[k] == 0) begin
						f[FB_SINGLE] = 1'b1;
						key_phase[k] = PH_IDLE;
					end
				end
				PH_SECOND, PH_LONG: begin
					if (!lvl)
						key_phase[k] = PH_IDLE;
				end
				default: key_phase[k] = PH_IDLE;
			endcase
			key_flags[k] = f;
		end
	endfunction

	function automatic press_rsp_t predict_press_rsp(logic o, logic [LEVELS_W-1:0] lv,
			logic [KEY_IDX_W-1:0] ki, flags_t fm);
		press_rsp_t r;
		flags_t     f;
		r = '0;
		if (o == OP_TICK) begin
			advance_keys(lv);
		end else if (ki < KEYS) begin
			f = key_flags[ki];
			r.flags = f;
			if ((f & fm) != 0) begin
				r.hit = 1'b1;
				if (fm != F_HELD)
					key_flags[ki] = f & ~fm;
			end
		end
		return r;
	endfunction

	task automatic send_req(logic o, logic [LEVELS_W-1:0] lv, logic [KEY_IDX_W-1:0] ki,
			flags_t fm);
		int gap;
		gap = sender_idles ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid  <= 1'b1;
		op         <= o;
		key_levels <= lv;
		key_index  <= ki;
		flag_mask  <= fm;
		do @(posedge clk); while (req_stall);
		pending_rsp.push_back(predict_press_rsp(o, lv, ki, fm));
		if (o == OP_TICK)
			n_ticks++;
		else
			n_checks++;
	endtask

	task automatic send_tick(logic [LEVELS_W-1:0] lv);
		send_req(OP_TICK, lv, KEY_IDX_W'($urandom), flags_t'($urandom));
	endtask

	task automatic send_check(logic [KEY_IDX_W-1:0] ki, flags_t fm);
		send_req(OP_CHECK, LEVELS_W'($urandom), ki, fm);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, tick_cnt_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_LONG_TICKS)
			long_ticks = val;
		else
			gap_ticks = val;
	endtask

	// only called with the block drained
	task automatic set_ticks(tick_cnt_t long_val, tick_cnt_t gap_val);
		write_reg(REG_LONG_TICKS, long_val);
		write_reg(REG_GAP_TICKS, gap_val);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	function automatic int draw_run(tick_cnt_t setting);
		int lim;
		lim = (setting == 0) ? 1 : ((setting > 40) ? 40 : int'(setting));
		return $urandom_range(0, 1) ? $urandom_range(1, lim) : $urandom_range(lim, lim + 6);
	endfunction

	function automatic flags_t draw_mask();
		case ($urandom_range(0, 7))
			0:       return F_HELD;
			1:       return '0;
			default: return flags_t'($urandom);
		endcase
	endfunction

	// mostly well-formed press/release runs sized around the tick settings
	task automatic random_presses(int count);
		logic [LEVELS_W-1:0] lv;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 3) begin
				send_check(KEY_IDX_W'($urandom), draw_mask());
			end else if ($urandom_range(0, 99) < 12) begin
				send_tick(LEVELS_W'($urandom));
			end else begin
				for (int k = 0; k < KEYS; k++) begin
					if (gen_run[k] == 0) begin
						gen_lvl[k] = !gen_lvl[k];
						gen_run[k] = draw_run(gen_lvl[k] ? long_ticks : gap_ticks);
					end
					gen_run[k]--;
					lv[k] = gen_lvl[k];
				end
				send_tick(lv);
			end
		end
	endtask

	task automatic test_directed_events();
		send_check(0, 6'h3F);
		send_check(3, 6'h3F);
		drain();
		set_ticks(3, 2);
		send_tick(4'hF);
		send_tick(4'h0);
		send_tick(4'hF);
		send_tick(4'h0);
		send_tick(4'h0);
		send_tick(4'h0);
		send_check(0, 6'h3F);
		send_check(1, F_HELD);
		send_check(2, '0);
		repeat (4) send_tick(4'h1);
		send_tick(4'h0);
		send_check(0, 6'h20);
		send_tick(4'h2);
		repeat (4) send_tick(4'h0);
		send_check(1, 6'h08);
		send_check(3, 6'h3F);
		drain();
	endtask

	task automatic test_press_sequences();
		tick_cnt_t settings [6][2] = '{'{1, 1}, '{3, 5}, '{8, 4}, '{20, 12},
			'{LONG_TICKS_RST, GAP_TICKS_RST}, '{0, 0}};
		settings[5][0] = TICK_W'($urandom_range(1, 30));
		settings[5][1] = TICK_W'($urandom_range(1, 30));
		for (int s = 0; s < 6; s++) begin
			set_ticks(settings[s][0], settings[s][1]);
			sender_idles = ($urandom_range(0, 3) != 0);
			receiver_idles = ($urandom_range(0, 3) != 0);
			random_presses(280);
			drain();
		end
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
	endtask

	task automatic test_zero_ticks();
		set_ticks(0, 0);
		random_presses(100);
		drain();
	endtask

	task automatic test_full_scale_ticks();
		set_ticks(16'hFFFF, 16'hFFFF);
		random_presses(100);
		drain();
	endtask

	task automatic test_backpressure();
		set_ticks(2, 3);
		sender_idles = 1'b0;
		hold_cycles = 80;
		random_presses(40);
		drain();
		sender_idles = 1'b1;
	endtask

	// response side: random stall per response, or one long hold on request
	initial begin : rsp_side
		int n;
		forever begin
			if (hold_cycles > 0) begin
				n = hold_cycles;
				hold_cycles = 0;
			end else begin
				n = receiver_idles ? $urandom_range(0, 12) : 0;
			end
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	always @(posedge clk) begin : rsp_check
		press_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$error("unexpected response: hit %0d flags_seen 0x%0h", hit, flags_seen);
				errors++;
			end else begin
				want = pending_rsp.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, hit);
					errors++;
				end
				if (flags_seen !== want.flags) begin
					$error("flags_seen: expected 0x%0h, got 0x%0h", want.flags, flags_seen);
					errors++;
				end
				if (want.hit)
					n_hits++;
			end
		end
	end

	initial begin
		#40_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		long_ticks = LONG_TICKS_RST;
		gap_ticks = GAP_TICKS_RST;
		for (int k = 0; k < KEYS; k++) begin
			key_lvl[k] = 1'b0;
			key_flags[k] = '0;
			key_phase[k] = PH_IDLE;
			key_cnt[k] = '0;
			gen_lvl[k] = 1'b0;
			gen_run[k] = 0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_events();
		test_press_sequences();
		test_zero_ticks();
		test_full_scale_ticks();
		test_backpressure();
		drain();

		$display("Ran %0d ticks and %0d flag checks (%0d hits) over %0d tick settings,",
			n_ticks, n_checks, n_hits, n_settings);
		$display("including zero and full-scale settings and a long output stall.");
		if (errors == 0 && pending_rsp.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
